@@ rtl/spig_pkg.sv @@
// Package for the step pulse item generator: move record, generator state,
// item result types and operation codes. No dependencies.
package spig_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [14:0] HALF_MAX     = 15'h7FFF;
  localparam logic [31:0] HALF_MAX_W   = 32'd32767;
  localparam logic [31:0] TWO_HALF_MAX = 32'd65534;

  // One queued move, packed as it arrives on the request bus
  typedef struct packed {
    logic signed [15:0] add;
    logic [15:0]        count;
    logic [31:0]        interval;
  } move_t;

  // Current move and pending filler
  typedef struct packed {
    logic [31:0]        interval;
    logic [15:0]        steps_left;
    logic signed [15:0] add;
    logic [31:0]        filler;
  } gen_state_t;

  // Outcome of one next operation
  typedef struct packed {
    gen_state_t  nxt;
    logic        pop;
    logic        item_valid;
    logic [14:0] first_duration;
    logic        first_level;
    logic [14:0] second_duration;
  } item_calc_t;

endpackage

@@ rtl/spig_move_mem.sv @@
// Move queue storage: one write port, one read port with registered data.
// Depends on spig_pkg for the move record.
module spig_move_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  spig_pkg::move_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output spig_pkg::move_t rdata_o
);
  import spig_pkg::*;

  move_t mem_q [DEPTH];
  move_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/spig_item_calc.sv @@
// Item arithmetic for a next operation: filler split, move pop and step pulse.
// Depends on spig_pkg for the state and result types.
module spig_item_calc (
  input  spig_pkg::gen_state_t cur_i,
  input  logic [14:0]          high_width_i,
  input  logic                 queue_empty_i,
  input  spig_pkg::move_t      move_i,
  output spig_pkg::item_calc_t res_o
);
  import spig_pkg::*;

  gen_state_t  src;
  logic        do_step;
  logic [31:0] iv;
  logic [31:0] hw_p1;
  logic [31:0] low;
  logic [31:0] rest;
  logic [14:0] dlow;
  logic [31:0] c_rem;

  always_comb begin
    res_o          = '0;
    res_o.nxt      = cur_i;
    src            = cur_i;
    do_step        = 1'b0;
    iv             = '0;
    hw_p1          = {17'd0, high_width_i} + 32'd1;
    low            = '0;
    rest           = '0;
    dlow           = '0;
    c_rem          = cur_i.filler - TWO_HALF_MAX;

    if (cur_i.filler != '0) begin
      // split pending low time into two low durations, carrying any excess to the next item
      res_o.item_valid  = 1'b1;
      res_o.first_level = 1'b0;
      if (cur_i.filler > TWO_HALF_MAX) begin
        res_o.first_duration  = HALF_MAX;
        res_o.second_duration = HALF_MAX;
        res_o.nxt.filler      = c_rem;
        if (c_rem == 32'd1) begin
          res_o.second_duration = HALF_MAX - 15'd1;
          res_o.nxt.filler      = 32'd2;
        end
      end else if (cur_i.filler > HALF_MAX_W) begin
        res_o.first_duration  = HALF_MAX;
        res_o.second_duration = 15'(cur_i.filler - HALF_MAX_W);
        res_o.nxt.filler      = '0;
      end else begin
        res_o.first_duration  = 15'(cur_i.filler - 32'd1);
        res_o.second_duration = 15'd1;
        res_o.nxt.filler      = '0;
      end
    end else if (cur_i.steps_left == '0) begin
      if (!queue_empty_i) begin
        res_o.pop          = 1'b1;
        src.interval       = move_i.interval;
        src.steps_left     = move_i.count;
        src.add            = move_i.add;
        res_o.nxt          = src;
        do_step            = (move_i.count != '0);
      end
    end else begin
      do_step = 1'b1;
    end

    if (do_step) begin
      iv                   = src.interval;
      res_o.nxt.interval   = iv + {{16{src.add[15]}}, src.add};
      res_o.nxt.steps_left = src.steps_left - 16'd1;
      low  = (iv > hw_p1) ? (iv - {17'd0, high_width_i}) : 32'd2;
      dlow = (low > HALF_MAX_W) ? HALF_MAX : low[14:0];
      rest = low - {17'd0, dlow};
      // never leave a single tick behind
      if (rest == 32'd1) begin
        dlow = dlow - 15'd1;
        rest = 32'd2;
      end
      res_o.nxt.filler      = rest;
      res_o.item_valid      = 1'b1;
      res_o.first_duration  = high_width_i;
      res_o.first_level     = 1'b1;
      res_o.second_duration = dlow;
    end
  end

endmodule

@@ rtl/step_pulse_item_generator_unit.sv @@
// Step pulse item generator: move queue in a synchronous memory, item logic
// and a registered result stage. Depends on spig_pkg, spig_move_mem, spig_item_calc.
// On acceptance the request and the move memory read are registered; the result register
// loads when the request commits, which waits while an earlier result is not yet taken.
// A new request is accepted only once the previous one has committed to the result register.
// The result register lets the next request in while a result waits to be taken.
// Reset: queue empty, current move and filler cleared, high_width 1; memory contents undefined.
module step_pulse_item_generator_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W = ((31 + QW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [14:0]      cfg_wdata_i,    // high_width
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,   // move_interval[31:0], move_count, move_add
  input  logic [1:0]       s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // first_duration, first_level, second_duration,
                                           // queue_free, zero fill
  output logic [1:0]       m_axis_tuser    // accepted, item_valid
);
  import spig_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(2 * QUEUE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(2 * QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
    return r[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] q_used(input logic [PW-1:0] h, input logic [PW-1:0] t);
    logic [PW:0] r;
    r = (h >= t) ? ({1'b0, h} - {1'b0, t})
                 : ({1'b0, h} + (PW+1)'(2 * QUEUE_DEPTH) - {1'b0, t});
    return r[PW-1:0];
  endfunction

  logic            state_q, state_d;
  logic [1:0]      req_op_q;
  move_t           req_move_q;
  logic [14:0]     high_width_q;
  gen_state_t      cur_q, cur_d;
  logic [PW-1:0]   head_q, head_d, tail_q, tail_d;
  logic            out_valid_q;
  logic [OUT_W-1:0] out_tdata_q, out_tdata_d;
  logic [1:0]      out_tuser_q, out_tuser_d;

  logic            s_accept;
  logic            commit;
  logic            q_full;
  logic            mem_we;
  move_t           mem_rdata;
  item_calc_t      calc;
  logic [PW-1:0]   used_d;
  logic            r_acc, r_valid, r_lvl;
  logic [14:0]     r_d0, r_d1;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign q_full        = (q_used(head_q, tail_q) == PW'(QUEUE_DEPTH));

  spig_move_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ptr_slot(head_q)),
    .wdata_i (req_move_q),
    .re_i    (s_accept),
    .raddr_i (ptr_slot(tail_q)),
    .rdata_o (mem_rdata)
  );

  spig_item_calc u_calc (
    .cur_i         (cur_q),
    .high_width_i  (high_width_q),
    .queue_empty_i (head_q == tail_q),
    .move_i        (mem_rdata),
    .res_o         (calc)
  );

  always_comb begin
    cur_d   = cur_q;
    head_d  = head_q;
    tail_d  = tail_q;
    mem_we  = 1'b0;
    r_acc   = 1'b1;
    r_valid = 1'b0;
    r_d0    = '0;
    r_lvl   = 1'b0;
    r_d1    = '0;
    unique case (req_op_q)
      OP_PUSH: begin
        if (q_full) begin
          r_acc = 1'b0;
        end else begin
          mem_we = commit;
          head_d = ptr_inc(head_q);
        end
      end
      OP_NEXT: begin
        cur_d   = calc.nxt;
        r_valid = calc.item_valid;
        r_d0    = calc.first_duration;
        r_lvl   = calc.first_level;
        r_d1    = calc.second_duration;
        if (calc.pop) begin
          tail_d = ptr_inc(tail_q);
        end
      end
      OP_START: begin
        cur_d.steps_left = '0;
        cur_d.filler     = '0;
      end
      OP_FLUSH: begin
        head_d = '0;
        tail_d = '0;
      end
      default: ;
    endcase
    used_d                  = q_used(head_d, tail_d);
    out_tdata_d             = '0;
    out_tdata_d[14:0]       = r_d0;
    out_tdata_d[15]         = r_lvl;
    out_tdata_d[30:16]      = r_d1;
    out_tdata_d[31 +: QW]   = QW'(PW'(QUEUE_DEPTH) - used_d);
    out_tuser_d             = {r_valid, r_acc};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_accept) state_d = ST_EXEC;
      ST_EXEC: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      high_width_q <= 15'd1;
      cur_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        high_width_q <= cfg_wdata_i;
      end
      if (commit) begin
        cur_q       <= cur_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the request while it is worked on, and load the result on commit
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_op_q   <= s_axis_tuser;
      req_move_q <= move_t'(s_axis_tdata);
    end
    if (commit) begin
      out_tdata_q <= out_tdata_d;
      out_tuser_q <= out_tuser_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && s_accept))
    else $error("move memory read and write in the same cycle");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_used(head_q, tail_q) <= PW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (req_op_q == OP_PUSH) && q_full) |=> $stable(head_q))
    else $error("refused push moved the head");

  a_item_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("item shown on a refused request");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_EXEC))
    else $error("accepted request not worked on");
`endif

endmodule
